// ===== src/sdspi_pkg.sv =====
// Shared types and constants for the SPI-mode SD card sequencer.
package sdspi_pkg;

  typedef enum logic [1:0] {
    OP_INIT     = 2'd0,
    OP_READ     = 2'd1,
    OP_EXCHANGE = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_WAKE   = 4'd1,
    PH_CMD0   = 4'd2,
    PH_CMD8   = 4'd3,
    PH_CMD55  = 4'd4,
    PH_ACMD41 = 4'd5,
    PH_CMD16  = 4'd6,
    PH_CMD17  = 4'd7,
    PH_TOKEN  = 4'd8,
    PH_DATA   = 4'd9,
    PH_TAIL   = 4'd10
  } phase_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_IDLE_ERR = 3'd1;
  localparam logic [2:0] ST_INIT_ERR = 3'd2;
  localparam logic [2:0] ST_BLEN_ERR = 3'd3;
  localparam logic [2:0] ST_RD_REJ   = 3'd4;
  localparam logic [2:0] ST_TOKEN_TO = 3'd5;

  localparam logic [2:0] REG_RESP_POLL = 3'd0;
  localparam logic [2:0] REG_IDLE_LIM  = 3'd1;
  localparam logic [2:0] REG_INIT_LIM  = 3'd2;
  localparam logic [2:0] REG_BLEN_LIM  = 3'd3;
  localparam logic [2:0] REG_TOKEN_LIM = 3'd4;

  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [7:0] START_TOKEN = 8'hFE;

  // Classified item handed from the front part to the sequencer.
  typedef struct packed {
    op_t         op;
    logic [31:0] block_number;
    logic [7:0]  received_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] send_byte;
    logic       send_valid;
    logic       card_selected;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       done_res;
    logic [2:0] status;
    logic       card_version;
    logic [7:0] last_response;
  } result_t;

  typedef struct packed {
    logic [7:0]  resp_poll;
    logic [7:0]  idle_lim;
    logic [15:0] init_lim;
    logic [7:0]  blen_lim;
    logic [15:0] token_lim;
  } limits_t;

endpackage

// ===== src/sdspi_front.sv =====
// Input stage: accepts items, classifies the operation and queues them.
module sdspi_front
  import sdspi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_block,
  input  logic [7:0]  in_rx,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);

  item_t      slot [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       push;
  logic       pop;
  item_t      incoming;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = slot[rd_ptr];

  always_comb begin
    incoming.op            = op_t'(in_op);
    incoming.block_number  = in_block;
    incoming.received_byte = in_rx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= incoming;
  end

endmodule

// ===== src/sdspi_seq.sv =====
// Sequencer: carries out one queued item per cycle while its result output is not stalled, and registers its result.
module sdspi_seq
  import sdspi_pkg::*;
#(
  parameter int BLOCK_BYTES = 512,
  parameter int WAKE_BYTES  = 10
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  output logic    q_ready,
  input  item_t   q_item,
  input  limits_t lim,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam logic [10:0] BLK_END = 11'(BLOCK_BYTES);
  localparam logic [9:0] WAKE_END = 10'(WAKE_BYTES);
  localparam logic [31:0] BLK_ARG = 32'(BLOCK_BYTES);

  phase_t      phase, phase_next;
  logic [9:0]  pos, pos_next;
  logic [15:0] attempts, attempts_next;
  // One bit beyond the widest limit so a poll count past 65535 still times out.
  logic [16:0] polls, polls_next;
  logic [2:0]  step, step_next;
  logic        kind, kind_next;
  logic [7:0]  err, err_next;
  logic [31:0] addr, addr_next;
  result_t     r;
  logic        take;

  assign q_ready = !res_valid || res_ready;
  assign take    = q_valid && q_ready;

  function automatic logic [7:0] frame_byte(phase_t ph, logic [2:0] idx, logic [31:0] a);
    logic [7:0]  cmd;
    logic [31:0] arg;
    logic [7:0]  crc;
    crc = IDLE_BYTE;
    unique case (ph)
      PH_CMD0:   begin cmd = 8'd0;  arg = 32'd0; crc = 8'h95; end
      PH_CMD8:   begin cmd = 8'd8;  arg = 32'h1AA; crc = 8'h87; end
      PH_CMD55:  begin cmd = 8'd55; arg = 32'd0; end
      PH_ACMD41: begin cmd = 8'd41; arg = 32'h4000_0000; end
      PH_CMD16:  begin cmd = 8'd16; arg = BLK_ARG; end
      default:   begin cmd = 8'd17; arg = a; end
    endcase
    unique case (idx)
      3'd0:    frame_byte = cmd | 8'h40;
      3'd1:    frame_byte = arg[31:24];
      3'd2:    frame_byte = arg[23:16];
      3'd3:    frame_byte = arg[15:8];
      3'd4:    frame_byte = arg[7:0];
      default: frame_byte = crc;
    endcase
  endfunction

  always_comb begin
    logic [7:0]  rx;
    logic [15:0] limit;
    logic        spent;
    logic [9:0]  pos_inc;
    rx            = q_item.received_byte;
    phase_next    = phase;
    pos_next      = pos;
    attempts_next = attempts;
    polls_next    = polls;
    step_next     = step;
    kind_next     = kind;
    err_next      = err;
    addr_next     = addr;
    limit         = 16'd0;
    spent         = 1'b0;
    pos_inc       = pos + 10'd1;
    r.send_byte     = IDLE_BYTE;
    r.send_valid    = 1'b0;
    r.card_selected = 1'b0;
    r.data_byte     = 8'd0;
    r.data_valid    = 1'b0;
    r.done_res      = 1'b0;
    r.status        = ST_OK;

    unique case (q_item.op)
      OP_INIT: begin
        phase_next = PH_WAKE; pos_next = 10'd1; attempts_next = 16'd0;
        polls_next = 17'd0; step_next = 3'd0;
        r.send_valid = 1'b1;
      end
      OP_READ: begin
        addr_next = q_item.block_number; attempts_next = 16'd0;
        phase_next = PH_CMD17; step_next = 3'd1; polls_next = 17'd0;
        r.send_byte = frame_byte(PH_CMD17, 3'd0, q_item.block_number);
        r.send_valid = 1'b1; r.card_selected = 1'b1;
      end
      OP_EXCHANGE: begin
        unique case (phase)
          PH_IDLE: ;
          PH_WAKE: begin
            if (pos < WAKE_END) begin
              pos_next = pos_inc; r.send_valid = 1'b1;
            end else begin
              attempts_next = 16'd0; phase_next = PH_CMD0; step_next = 3'd1;
              polls_next = 17'd0;
              r.send_byte = frame_byte(PH_CMD0, 3'd0, addr);
              r.send_valid = 1'b1; r.card_selected = 1'b1;
            end
          end
          PH_TOKEN: begin
            if (rx == START_TOKEN) begin
              phase_next = PH_DATA; pos_next = 10'd0;
              r.send_valid = 1'b1; r.card_selected = 1'b1;
            end else if (polls > {1'b0, lim.token_lim}) begin
              err_next = rx; phase_next = PH_IDLE;
              r.done_res = 1'b1; r.status = ST_TOKEN_TO;
            end else begin
              polls_next = polls + 17'd1;
              r.send_valid = 1'b1; r.card_selected = 1'b1;
            end
          end
          PH_DATA: begin
            r.data_byte = rx; r.data_valid = 1'b1;
            r.send_valid = 1'b1; r.card_selected = 1'b1;
            // Compare in 11 bits so a full 1024-byte block still ends.
            if ({1'b0, pos} + 11'd1 >= BLK_END) begin
              phase_next = PH_TAIL; pos_next = 10'd1;
            end else begin
              pos_next = pos_inc;
            end
          end
          PH_TAIL: begin
            if (pos < 10'd3) begin
              pos_next = pos_inc; r.send_valid = 1'b1; r.card_selected = 1'b1;
            end else begin
              phase_next = PH_IDLE; r.done_res = 1'b1; r.status = ST_OK;
            end
          end
          default: begin
            if (step < 3'd6) begin
              r.send_byte = frame_byte(phase, step, addr);
              r.send_valid = 1'b1; r.card_selected = 1'b1;
              step_next = step + 3'd1;
            end else if (step == 3'd6) begin
              step_next = 3'd7; polls_next = 17'd0;
              r.send_valid = 1'b1; r.card_selected = 1'b1;
            end else if (rx == IDLE_BYTE && polls <= {9'd0, lim.resp_poll}) begin
              polls_next = polls + 17'd1;
              r.send_valid = 1'b1; r.card_selected = 1'b1;
            end else begin
              // Response received: decide the next command.
              priority case (phase)
                PH_CMD0:   limit = {8'd0, lim.idle_lim};
                PH_ACMD41: limit = lim.init_lim;
                PH_CMD16:  limit = {8'd0, lim.blen_lim};
                default:   limit = 16'd0;
              endcase
              spent = (attempts >= limit);
              if ((phase == PH_CMD0 || phase == PH_ACMD41 || phase == PH_CMD16)
                  && !spent) begin
                attempts_next = attempts + 16'd1;
              end
              step_next = 3'd1; polls_next = 17'd0;
              r.send_valid = 1'b1; r.card_selected = 1'b1;
              unique case (phase)
                PH_CMD0: begin
                  if (spent) begin
                    err_next = rx; phase_next = PH_IDLE;
                  end else if (rx == 8'h01) phase_next = PH_CMD8;
                  else phase_next = PH_CMD0;
                  if (spent) begin
                    r.done_res = 1'b1; r.status = ST_IDLE_ERR;
                  end
                end
                PH_CMD8: begin
                  kind_next = ~rx[2]; attempts_next = 16'd0;
                  phase_next = PH_CMD55;
                end
                PH_CMD55: phase_next = PH_ACMD41;
                PH_ACMD41: begin
                  if (spent) begin
                    err_next = rx; phase_next = PH_IDLE;
                    r.done_res = 1'b1; r.status = ST_INIT_ERR;
                  end else if (rx == 8'h00) begin
                    attempts_next = 16'd0; phase_next = PH_CMD16;
                  end else phase_next = PH_CMD55;
                end
                PH_CMD16: begin
                  if (spent) begin
                    err_next = rx; phase_next = PH_IDLE;
                    r.done_res = 1'b1; r.status = ST_BLEN_ERR;
                  end else if (rx == 8'h00) begin
                    phase_next = PH_IDLE; r.done_res = 1'b1; r.status = ST_OK;
                  end else phase_next = PH_CMD16;
                end
                default: begin
                  err_next = rx;
                  if (rx != 8'h00) begin
                    phase_next = PH_IDLE; r.done_res = 1'b1; r.status = ST_RD_REJ;
                  end else begin
                    phase_next = PH_TOKEN; step_next = step;
                  end
                end
              endcase
              if (r.done_res) begin
                r.send_valid = 1'b0; r.card_selected = 1'b0; step_next = step;
                polls_next = polls;
              end else if (phase_next != PH_TOKEN) begin
                r.send_byte = frame_byte(phase_next, 3'd0, addr);
              end
            end
          end
        endcase
      end
      default: ;
    endcase
    r.card_version  = kind_next;
    r.last_response = err_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      pos       <= 10'd0;
      attempts  <= 16'd0;
      polls     <= 17'd0;
      step      <= 3'd0;
      kind      <= 1'b0;
      err       <= 8'd0;
      addr      <= 32'd0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        phase    <= phase_next;
        pos      <= pos_next;
        attempts <= attempts_next;
        polls    <= polls_next;
        step     <= step_next;
        kind     <= kind_next;
        err      <= err_next;
        addr     <= addr_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) res <= r;
  end

endmodule

// ===== src/sd_spi_init_and_block_read.sv =====
// Top level of the SPI-mode SD card initialization and block read sequencer.
//  channel   direction  fields (tdata low bit up)
//  s_axis    in         operation[1:0], block_number[33:2], received_byte[41:34]
//  m_axis    out        send_byte..last_response, 32 bits
//  cfg       in         we, index, 16-bit data
// An accepted item is written into the two-entry input queue, and the sequencer
// then registers its result; a new item may enter each cycle while m_axis is not
// stalled. The registered result waits for m_axis_tready.
// Reset is synchronous; limits return to their defaults and the phase to idle.
// Either side may stall without losing a transaction.
module sd_spi_init_and_block_read
  import sdspi_pkg::*;
#(
  parameter int BLOCK_BYTES = 512,
  parameter int WAKE_BYTES  = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[1:0], block_number[33:2], received_byte[41:34], zero fill
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // send_byte, send_valid, card_selected, data_byte, data_valid, done_res,
  // status, card_version, last_response
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  limits_t lim;
  logic    q_valid, q_ready;
  item_t   q_item;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim.resp_poll <= 8'd254;
      lim.idle_lim  <= 8'd254;
      lim.init_lim  <= 16'd20254;
      lim.blen_lim  <= 8'd10;
      lim.token_lim <= 16'd1600;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESP_POLL: lim.resp_poll <= cfg_data[7:0];
        REG_IDLE_LIM:  lim.idle_lim  <= cfg_data[7:0];
        REG_INIT_LIM:  lim.init_lim  <= cfg_data;
        REG_BLEN_LIM:  lim.blen_lim  <= cfg_data[7:0];
        REG_TOKEN_LIM: lim.token_lim <= cfg_data;
        default: ;
      endcase
    end
  end

  sdspi_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_op(s_axis_tdata[1:0]), .in_block(s_axis_tdata[33:2]),
    .in_rx(s_axis_tdata[41:34]),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  sdspi_seq #(.BLOCK_BYTES(BLOCK_BYTES), .WAKE_BYTES(WAKE_BYTES)) u_seq (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item), .lim(lim),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tdata = {res.last_response, res.card_version, res.status,
                         res.done_res, res.data_valid, res.data_byte,
                         res.card_selected, res.send_valid, res.send_byte};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[19] |-> m_axis_tdata[22:20] == ST_OK)
    else $error("status set without done");
  a_sel: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[8] |-> !m_axis_tdata[9])
    else $error("card selected without exchange");

endmodule

// ===== tb/sv/sd_spi_init_and_block_read_tb.sv =====
// Self-checking testbench for the SPI-mode SD card init and block read sequencer.
`timescale 1ns / 1ps

module sd_spi_init_and_block_read_tb;
  import sdspi_pkg::*;

  localparam int BLOCK_LEN = 512;
  localparam int WAKE_LEN  = 10;

  // Declared from the highest field down so that it overlays m_axis_tdata.
  typedef struct packed {
    logic [7:0] last_response;
    logic       card_version;
    logic [2:0] status;
    logic       done_res;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       card_selected;
    logic       send_valid;
    logic [7:0] send_byte;
  } sd_out_t;

  // Behavioral copy of the sequencer; predicts one result per accepted item.
  class sd_scoreboard;
    sd_out_t pending[$];
    int errors;
    logic [7:0] resp_lim, idle_lim, blen_lim;
    logic [15:0] init_lim, tok_lim;
    phase_t ph;
    int unsigned pos, tries, polls, step;
    logic kind;
    logic [7:0] err_resp;
    logic [31:0] addr;
    sd_out_t r;

    function new();
      errors = 0;
      resp_lim = 254; idle_lim = 254; init_lim = 20254; blen_lim = 10; tok_lim = 1600;
      ph = PH_IDLE; pos = 0; tries = 0; polls = 0; step = 0;
      kind = 0; err_resp = 0; addr = 0;
    endfunction

    function void set_limit(logic [2:0] idx, logic [15:0] v);
      case (idx)
        REG_RESP_POLL: resp_lim = v[7:0];
        REG_IDLE_LIM:  idle_lim = v[7:0];
        REG_INIT_LIM:  init_lim = v;
        REG_BLEN_LIM:  blen_lim = v[7:0];
        REG_TOKEN_LIM: tok_lim = v;
        default: ;
      endcase
    endfunction

    function void send(logic [7:0] b);
      r.send_byte = b; r.send_valid = 1; r.card_selected = 1;
    endfunction

    function void finish_op(logic [2:0] st);
      ph = PH_IDLE; r.done_res = 1; r.status = st;
    endfunction

    function logic [7:0] frame_byte(phase_t p, int unsigned idx);
      logic [7:0] cmd, crc;
      logic [31:0] arg;
      crc = 8'hFF;
      case (p)
        PH_CMD0:   begin cmd = 0;  arg = 0; crc = 8'h95; end
        PH_CMD8:   begin cmd = 8;  arg = 32'h1AA; crc = 8'h87; end
        PH_CMD55:  begin cmd = 55; arg = 0; end
        PH_ACMD41: begin cmd = 41; arg = 32'h4000_0000; end
        PH_CMD16:  begin cmd = 16; arg = BLOCK_LEN; end
        default:   begin cmd = 17; arg = addr; end
      endcase
      if (idx == 0) return cmd | 8'h40;
      if (idx >= 5) return crc;
      return 8'(arg >> (8 * (4 - idx)));
    endfunction

    function void begin_cmd(phase_t p);
      ph = p; step = 1; polls = 0; send(frame_byte(p, 0));
    endfunction

    // True once the attempt just made exceeds the retry budget.
    function bit budget_spent(int unsigned lim);
      if (tries >= lim) return 1;
      tries = (tries + 1) & 16'hFFFF;
      return 0;
    endfunction

    function void response_in(logic [7:0] rx);
      case (ph)
        PH_CMD0:
          if (budget_spent(idle_lim)) begin err_resp = rx; finish_op(ST_IDLE_ERR); end
          else if (rx == 8'h01) begin_cmd(PH_CMD8);
          else begin_cmd(PH_CMD0);
        PH_CMD8: begin
          kind = rx[2] ? 1'b0 : 1'b1; tries = 0; begin_cmd(PH_CMD55);
        end
        PH_CMD55: begin_cmd(PH_ACMD41);
        PH_ACMD41:
          if (budget_spent(init_lim)) begin err_resp = rx; finish_op(ST_INIT_ERR); end
          else if (rx == 8'h00) begin tries = 0; begin_cmd(PH_CMD16); end
          else begin_cmd(PH_CMD55);
        PH_CMD16:
          if (budget_spent(blen_lim)) begin err_resp = rx; finish_op(ST_BLEN_ERR); end
          else if (rx == 8'h00) finish_op(ST_OK);
          else begin_cmd(PH_CMD16);
        default: begin
          err_resp = rx;
          if (rx != 8'h00) finish_op(ST_RD_REJ);
          else begin ph = PH_TOKEN; polls = 0; send(IDLE_BYTE); end
        end
      endcase
    endfunction

    function void byte_in(logic [7:0] rx);
      case (ph)
        PH_WAKE:
          if (pos < WAKE_LEN) begin pos++; send(IDLE_BYTE); r.card_selected = 0; end
          else begin tries = 0; begin_cmd(PH_CMD0); end
        PH_TOKEN:
          if (rx == START_TOKEN) begin ph = PH_DATA; pos = 0; send(IDLE_BYTE); end
          else if (polls > tok_lim) begin err_resp = rx; finish_op(ST_TOKEN_TO); end
          else begin polls++; send(IDLE_BYTE); end
        PH_DATA: begin
          r.data_byte = rx; r.data_valid = 1; pos++;
          if (pos >= BLOCK_LEN) begin ph = PH_TAIL; pos = 1; end
          send(IDLE_BYTE);
        end
        PH_TAIL:
          if (pos < 3) begin pos++; send(IDLE_BYTE); end
          else finish_op(ST_OK);
        default:
          if (step < 6) begin send(frame_byte(ph, step)); step++; end
          else if (step == 6) begin step = 7; polls = 0; send(IDLE_BYTE); end
          else if (rx == 8'hFF && polls <= resp_lim) begin polls++; send(IDLE_BYTE); end
          else response_in(rx);
      endcase
    endfunction

    function void note_item(logic [47:0] d);
      op_t op;
      op = op_t'(d[1:0]);
      r = '0; r.send_byte = 8'hFF;
      if (op == OP_INIT) begin
        ph = PH_WAKE; pos = 1; tries = 0; polls = 0; step = 0;
        send(IDLE_BYTE); r.card_selected = 0;
      end else if (op == OP_READ) begin
        addr = d[33:2]; tries = 0; begin_cmd(PH_CMD17);
      end else if (op == OP_EXCHANGE && ph != PH_IDLE) begin
        byte_in(d[41:34]);
      end
      r.card_version = kind; r.last_response = err_resp;
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] d);
      sd_out_t a, e;
      a = d;
      if (pending.size() == 0) begin
        $error("unexpected result %h", d); errors++; return;
      end
      e = pending.pop_front();
      if (a.send_byte != e.send_byte) begin
        $error("send_byte exp %h got %h", e.send_byte, a.send_byte); errors++; end
      if (a.send_valid != e.send_valid) begin
        $error("send_valid exp %h got %h", e.send_valid, a.send_valid); errors++; end
      if (a.card_selected != e.card_selected) begin
        $error("card_selected exp %h got %h", e.card_selected, a.card_selected); errors++; end
      if (a.data_byte != e.data_byte) begin
        $error("data_byte exp %h got %h", e.data_byte, a.data_byte); errors++; end
      if (a.data_valid != e.data_valid) begin
        $error("data_valid exp %h got %h", e.data_valid, a.data_valid); errors++; end
      if (a.done_res != e.done_res) begin
        $error("done_res exp %h got %h", e.done_res, a.done_res); errors++; end
      if (a.status != e.status) begin
        $error("status exp %h got %h", e.status, a.status); errors++; end
      if (a.card_version != e.card_version) begin
        $error("card_version exp %h got %h", e.card_version, a.card_version); errors++; end
      if (a.last_response != e.last_response) begin
        $error("last_response exp %h got %h", e.last_response, a.last_response); errors++; end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  sd_scoreboard sb = new();
  bit calm;  // no idling on either side while set
  int n_items;

  always #5 clk = ~clk;

  sd_spi_init_and_block_read dut (.*);

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 10);
    end
  end

  // Leaves tvalid high on return; the next call may take it down, and drain() does.
  task automatic push_item(op_t op, logic [31:0] blk, logic [7:0] rx);
    while (!calm && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'b0, rx, blk, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_items++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0 && guard < 100000) begin @(posedge clk); guard++; end
    repeat (10) @(posedge clk);
  endtask

  task automatic write_limit(logic [2:0] idx, logic [15:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_limit(idx, v);
    @(posedge clk);
  endtask

  // Card answer: mostly what moves the sequencer forward, sometimes noise.
  function automatic logic [7:0] card_byte();
    logic [7:0] v;
    case (sb.ph)
      PH_CMD0:   v = ($urandom_range(3) != 0) ? 8'h01 : 8'h05;
      PH_CMD8:   v = ($urandom_range(1) != 0) ? 8'h05 : 8'h01;
      PH_ACMD41: v = ($urandom_range(2) == 0) ? 8'h00 : 8'h01;
      PH_CMD16, PH_CMD17: v = ($urandom_range(5) != 0) ? 8'h00 : 8'($urandom_range(255));
      PH_TOKEN:  v = ($urandom_range(2) == 0) ? START_TOKEN : 8'hFF;
      default:   v = 8'($urandom_range(255));
    endcase
    if (sb.step == 7 && sb.ph inside {[PH_CMD0:PH_CMD17]} && $urandom_range(2) == 0)
      v = 8'hFF;
    if ($urandom_range(19) == 0) v = 8'($urandom_range(255));
    return v;
  endfunction

  task automatic run_exchanges(int count);
    for (int i = 0; i < count; i++) push_item(OP_EXCHANGE, $urandom, card_byte());
  endtask

  initial begin
    calm = 0;
    n_items = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: ignored items, then an init cut short by a read, and a partial read.
    push_item(OP_EXCHANGE, 32'hFFFF_FFFF, 8'hFF);
    push_item(OP_NONE, 32'h0, 8'h00);
    drain();
    write_limit(REG_TOKEN_LIM, 16'd0);
    write_limit(REG_RESP_POLL, 16'd0);
    push_item(OP_INIT, 32'h0, 8'h00);
    run_exchanges(8);
    push_item(OP_READ, 32'hFFFF_FFFF, 8'hFF);
    run_exchanges(9);
    drain();

    // Phases of different limit settings; extremes included.
    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: begin write_limit(REG_RESP_POLL, 255); write_limit(REG_IDLE_LIM, 1);
                 write_limit(REG_INIT_LIM, 1); write_limit(REG_BLEN_LIM, 1);
                 write_limit(REG_TOKEN_LIM, 0); end
        1: begin write_limit(REG_RESP_POLL, 0); write_limit(REG_IDLE_LIM, 255);
                 write_limit(REG_INIT_LIM, 16'hFFFF); write_limit(REG_BLEN_LIM, 255);
                 write_limit(REG_TOKEN_LIM, 16'hFFFF); end
        default: begin
          write_limit(REG_RESP_POLL, 16'($urandom_range(3)));
          write_limit(REG_IDLE_LIM, 16'($urandom_range(1, 6)));
          write_limit(REG_INIT_LIM, 16'($urandom_range(1, 8)));
          write_limit(REG_BLEN_LIM, 16'($urandom_range(1, 4)));
          write_limit(REG_TOKEN_LIM, 16'($urandom_range(4)));
        end
      endcase
      calm = (p == 3);
      while (n_items < 25 + (p + 1) * 215) begin
        if ($urandom_range(99) < 4 || sb.ph == PH_IDLE)
          push_item(op_t'($urandom_range(99) < 40 ? OP_INIT
                          : ($urandom_range(9) == 0 ? OP_NONE : OP_READ)),
                    $urandom, 8'($urandom));
        else
          push_item(OP_EXCHANGE, $urandom, card_byte());
      end
      calm = 0;
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

endmodule
